[design/mlpd_pkg.sv]
// package for the magic/length-prefixed deframer
// holds marker bytes, phase and result-kind codes, the result struct
// no dependencies
package mlpd_pkg;

    localparam logic [7:0] MARK_FIRST  = 8'h50;  // 'P'
    localparam logic [7:0] MARK_SECOND = 8'h42;  // 'B'

    localparam int unsigned MAX_LEN_W     = 31;
    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 31'd65536;

    localparam int unsigned PHASE_W = 3;
    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_MARK = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN0 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LEN1 = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LEN2 = 3'd4;
    localparam logic [PHASE_W-1:0] PH_LEN3 = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd6;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       last;
    } res_t;

endpackage

[design/magic_length_prefix_deframer.sv]
// magic_length_prefix_deframer: byte-stream deframer, top level
// hunts for the 'P','B' marker, reads a 4-byte length, passes the payload
// depends on mlpd_pkg
//
// usage:
//   s_* carries one received byte per transfer (s_tdata[7:0]).
//   m_* carries one result per transfer: m_tdata[7:0] payload byte,
//   m_tuser[1:0] kind (payload, empty frame, bad length), m_tlast marks
//   the last result of a frame (also set on empty-frame and error results).
//   cfg_we/cfg_wdata write max_len; write it only while the block is idle.
// throughput:
//   one byte accepted per cycle while s_tready is high; each result is held
//   in the output (or skid) register. the frame state is updated in the same
//   cycle the byte is accepted, so the phase/length registers set the rate.
// stalls:
//   the output register is backed by a one-entry skid register, so the
//   block keeps accepting while one result waits; s_tready drops only
//   when both hold a result.
// reset:
//   aresetn (synchronous, active low) returns to marker hunt, empties the
//   output stages and sets max_len to 65536.
module magic_length_prefix_deframer
    import mlpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // input byte stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,    // [7:0] rx_byte
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,    // [7:0] payload_byte
    output logic [1:0]           m_tuser,    // [1:0] kind
    output logic                 m_tlast,
    // max_len register
    input  logic                 cfg_we,
    input  logic [MAX_LEN_W-1:0] cfg_wdata
);

    // frame state
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [31:0]          length_reg, length_next;
    logic [MAX_LEN_W-1:0] remaining_reg, remaining_next;
    logic [MAX_LEN_W-1:0] max_len_reg;

    // output register and skid register
    logic out_valid_reg, skid_valid_reg;
    res_t out_reg, skid_reg;

    logic        accept;
    logic        res_valid;
    res_t        res;
    logic [31:0] full_len;
    logic        fin;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // length with the fourth byte on top (little endian)
    assign full_len = {s_tdata, length_reg[31:8]};
    assign fin      = (remaining_reg <= MAX_LEN_W'(1));

    // per-byte state update
    always_comb begin
        phase_next     = phase_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        res_valid      = 1'b0;
        res            = '{kind: KIND_DATA, payload_byte: 8'h00, last: 1'b0};
        unique case (phase_reg)
            PH_MARK: begin
                if (s_tdata == MARK_SECOND) begin
                    phase_next = PH_LEN0;
                end else if (s_tdata == MARK_FIRST) begin
                    phase_next = PH_MARK;   // keep the new 'P'
                end else begin
                    phase_next = PH_HUNT;
                end
            end
            PH_LEN0, PH_LEN1, PH_LEN2: begin
                length_next = full_len;
                phase_next  = phase_reg + PHASE_W'(1);
            end
            PH_LEN3: begin
                length_next = full_len;
                if (full_len[31] || (full_len[30:0] > max_len_reg)) begin
                    // negative or too long
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res        = '{kind: KIND_BAD, payload_byte: 8'h00, last: 1'b1};
                end else if (full_len == 32'd0) begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res        = '{kind: KIND_EMPTY, payload_byte: 8'h00, last: 1'b1};
                end else begin
                    remaining_next = full_len[30:0];
                    phase_next     = PH_DATA;
                end
            end
            PH_DATA: begin
                res_valid = 1'b1;
                res       = '{kind: KIND_DATA, payload_byte: s_tdata, last: fin};
                if (fin) begin
                    remaining_next = '0;
                    phase_next     = PH_HUNT;
                end else begin
                    remaining_next = remaining_reg - MAX_LEN_W'(1);
                end
            end
            default: begin
                // hunting, and the unused code
                phase_next = (s_tdata == MARK_FIRST) ? PH_MARK : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HUNT;
            remaining_reg <= '0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
        end
    end

    // length bytes are all shifted in before use, so no reset needed
    always_ff @(posedge aclk) begin
        if (accept) begin
            length_reg <= length_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_we) begin
            max_len_reg <= cfg_wdata;
        end
    end

    // output stage with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            // output frees: drain skid first, else take the new result
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= accept && res_valid;
            end
        end else if (accept && res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        if (accept && res_valid && out_valid_reg && !m_tready) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.payload_byte;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

`ifndef SYNTHESIS
    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output is empty");

    // non-payload results always close the frame and carry no byte
    a_ctrl_result_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != KIND_DATA)) |-> (m_tlast && (m_tdata == 8'h00)))
        else $error("empty/error result without last or with data");

    // the final payload byte returns the block to hunting
    a_last_byte_hunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (phase_reg == PH_DATA) && fin) |=> (phase_reg == PH_HUNT))
        else $error("no return to hunt after the last payload byte");

    // a payload transfer appears only from the payload phase
    a_data_from_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_valid && (res.kind == KIND_DATA)) |-> (phase_reg == PH_DATA))
        else $error("payload result outside the payload phase");
`endif

endmodule

[verif/magic_length_prefix_deframer_tb.sv]
// testbench for magic_length_prefix_deframer: directed and random byte streams
// with random stalls on both sides, results checked against a built-in predictor
// depends on mlpd_pkg and the deframer RTL
module magic_length_prefix_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlpd_pkg::*;

    localparam int unsigned RX_BYTES_TOTAL = 1950;  // random bytes over all max_len settings
    localparam int unsigned N_SETTINGS     = 6;
    localparam int unsigned QUIET_LIMIT    = 1000;  // cycles with no transfer on either side
    localparam int unsigned DRAIN_CYCLES   = 8;     // spare cycles after the last expected result

    // frame predictor and expected-result store
    class frame_scoreboard;
        logic [PHASE_W-1:0]   phase;
        logic [31:0]          len_acc;
        logic [MAX_LEN_W-1:0] remaining;
        logic [MAX_LEN_W-1:0] max_len;
        res_t                 frame_results_q[$];
        int                   errors;

        function new();
            phase     = PH_HUNT;
            len_acc   = '0;
            remaining = '0;
            max_len   = MAX_LEN_RESET;
            errors    = 0;
        endfunction

        function void set_max_len(logic [MAX_LEN_W-1:0] v);
            max_len = v;
        endfunction

        // advance the frame state by one accepted byte, queue any result
        function void note_rx_byte(logic [7:0] b);
            res_t r;
            logic fin;
            case (phase)
                PH_MARK: begin
                    if (b == MARK_SECOND) begin
                        len_acc = '0;
                        phase   = PH_LEN0;
                    end else if (b == MARK_FIRST) begin
                        phase = PH_MARK;  // a second 'P' restarts the marker
                    end else begin
                        phase = PH_HUNT;
                    end
                end
                PH_LEN0, PH_LEN1, PH_LEN2: begin
                    len_acc = {b, len_acc[31:8]};  // little-endian, newest byte on top
                    phase   = phase + 1'b1;
                end
                PH_LEN3: begin
                    len_acc = {b, len_acc[31:8]};
                    if (len_acc[31] || len_acc[30:0] > max_len) begin
                        r = '{kind: KIND_BAD, payload_byte: 8'h00, last: 1'b1};
                        frame_results_q.push_back(r);
                        phase = PH_HUNT;
                    end else if (len_acc == '0) begin
                        r = '{kind: KIND_EMPTY, payload_byte: 8'h00, last: 1'b1};
                        frame_results_q.push_back(r);
                        phase = PH_HUNT;
                    end else begin
                        remaining = len_acc[30:0];
                        phase     = PH_DATA;
                    end
                end
                PH_DATA: begin
                    fin = (remaining <= 1);
                    r   = '{kind: KIND_DATA, payload_byte: b, last: fin};
                    frame_results_q.push_back(r);
                    if (fin) begin
                        remaining = '0;
                        phase     = PH_HUNT;
                    end else begin
                        remaining = remaining - 1'b1;
                    end
                end
                default: begin
                    // hunting, and the unused phase code behaves the same
                    phase = (b == MARK_FIRST) ? PH_MARK : PH_HUNT;
                end
            endcase
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
            res_t e;
            if (frame_results_q.size() == 0) begin
                $error("unexpected result: kind %0d, payload_byte 0x%02h, last %0d",
                       kind, data, last);
                errors++;
                return;
            end
            e = frame_results_q.pop_front();
            if (kind !== e.kind) begin
                $error("kind: expected %0d, got %0d", e.kind, kind);
                errors++;
            end
            if (data !== e.payload_byte) begin
                $error("payload_byte: expected 0x%02h, got 0x%02h", e.payload_byte, data);
                errors++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;    // [7:0] payload_byte
    logic [1:0]           m_tuser;    // [1:0] kind
    logic                 m_tlast;
    logic                 cfg_we;
    logic [MAX_LEN_W-1:0] cfg_wdata;

    frame_scoreboard sb = new();

    int  rx_sent;       // bytes accepted by the block so far
    int  quiet_cycles;
    int  ready_stall;
    bit  tx_burst;      // sender runs without gaps while set
    bit  rx_burst;      // receiver starts no new stall while set

    magic_length_prefix_deframer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // receiver side: random stall stretches, with bursts of constant ready
    always @(posedge aclk) begin
        if (ready_stall > 0) begin
            m_tready <= 1'b0;
            ready_stall--;
        end else if (!rx_burst && $urandom_range(0, 99) < 30) begin
            m_tready <= 1'b0;
            ready_stall = pick_gap();
        end else begin
            m_tready <= 1'b1;
        end
        if ($urandom_range(0, 199) == 0) begin
            rx_burst = !rx_burst;
        end
    end

    // both channels observed at the edge: input transfers feed the predictor
    // first, so a result of the same edge always finds its expectation
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_rx_byte(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tuser, m_tdata, m_tlast);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("magic_length_prefix_deframer_tb: done, errors");
                $finish;
            end
        end
    end

    // one byte transfer, with an optional gap in front
    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        rx_sent++;
    endtask

    // stop sending and let every expected result come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.frame_results_q.size() != 0) @(posedge aclk);
        // header bytes give no result, so allow the block to settle
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_len(input logic [MAX_LEN_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_max_len(v);
    endtask

    // noise, then one frame: good, empty or with a bad length
    task automatic send_random_frame();
        int                   n_noise;
        int                   pick;
        int unsigned          n_pay;
        logic [7:0]           b;
        logic [7:0]           prev;
        logic [31:0]          flen;
        logic [MAX_LEN_W-1:0] lim;
        lim   = sb.max_len;
        n_pay = 0;
        prev  = 8'h00;

        // noise is kept free of a full marker, so that a runaway length
        // cannot swallow the rest of the stream; a lone 'P' is common
        n_noise = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 6);
        for (int i = 0; i < n_noise; i++) begin
            b = ($urandom_range(0, 3) == 0) ? MARK_FIRST : 8'($urandom);
            if (prev == MARK_FIRST && b == MARK_SECOND) begin
                b = MARK_SECOND + 8'd1;
            end
            send_rx_byte(b);
            prev = b;
        end

        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            flen = '0;
        end else if (pick < 20) begin
            if (lim == '1 || $urandom_range(0, 1) == 1) begin
                flen = {1'b1, 31'($urandom)};                  // negative length
            end else if ($urandom_range(0, 1) == 1) begin
                flen = {1'b0, lim} + 32'd1;                    // just over the limit
            end else begin
                flen = $urandom_range(32'h7FFF_FFFF, {1'b0, lim} + 32'd1);
            end
        end else begin
            n_pay = (pick < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
            if (lim <= 40 && $urandom_range(0, 9) == 0) begin
                n_pay = {1'b0, lim};                           // exactly at the limit
            end
            if (n_pay > lim) begin
                n_pay = (lim == 0) ? 0 : $urandom_range(1, lim);
            end
            flen = n_pay;
        end

        send_rx_byte(MARK_FIRST);
        send_rx_byte(MARK_SECOND);
        for (int i = 0; i < 4; i++) begin
            send_rx_byte(flen[8*i +: 8]);
        end
        for (int unsigned i = 0; i < n_pay; i++) begin
            send_rx_byte(8'($urandom));
        end

        if ($urandom_range(0, 9) == 0) begin
            tx_burst = !tx_burst;
        end
        // now and then the sender holds off until the output side is empty
        if ($urandom_range(0, 49) == 0) begin
            drain_results();
        end
    endtask

    initial begin
        logic [7:0]           directed_q[$];
        logic [MAX_LEN_W-1:0] settings[N_SETTINGS];
        int                   target;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        m_tready  <= 1'b0;
        rx_sent      = 0;
        quiet_cycles = 0;
        ready_stall  = 0;
        tx_burst     = 1'b0;
        rx_burst     = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, under the reset limit of 65536
        directed_q = '{
            // 'P' then a non-'B' drops the marker; 'P','P','B' keeps the second 'P';
            // zero length gives the empty-frame result
            MARK_FIRST, 8'h58, MARK_FIRST, MARK_FIRST, MARK_SECOND,
            8'h00, 8'h00, 8'h00, 8'h00,
            // four payload bytes: both byte extremes and marker bytes passed through
            MARK_FIRST, MARK_SECOND, 8'h04, 8'h00, 8'h00, 8'h00,
            8'hFF, 8'h00, MARK_FIRST, MARK_SECOND,
            // all-ones length is negative
            MARK_FIRST, MARK_SECOND, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            // 65537 is one over the limit
            MARK_FIRST, MARK_SECOND, 8'h01, 8'h00, 8'h01, 8'h00
        };
        foreach (directed_q[i]) begin
            send_rx_byte(directed_q[i]);
        end
        drain_results();

        // random part over a sweep of max_len settings, extremes included
        settings[0] = MAX_LEN_RESET;
        settings[1] = '1;
        settings[2] = '0;
        settings[3] = 31'd1;
        settings[4] = 31'd3;
        settings[5] = MAX_LEN_W'($urandom_range(4, 40));
        for (int s = 0; s < N_SETTINGS; s++) begin
            if (s > 0) begin
                write_max_len(settings[s]);
            end
            target = directed_q.size() + (s + 1) * RX_BYTES_TOTAL / N_SETTINGS;
            while (rx_sent < target) begin
                send_random_frame();
            end
            drain_results();
        end

        if (sb.errors == 0 && sb.frame_results_q.size() == 0) begin
            $display("magic_length_prefix_deframer_tb: done, clean");
        end else begin
            $display("magic_length_prefix_deframer_tb: done, errors");
        end
        $finish;
    end

endmodule
